### rtl/clin_pkg.sv
// Shared types, constants and the sequencer program of the clamped linear interpolator.
`timescale 1ns / 1ps

package clin_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_W     = 9;
  localparam int INDEX_W     = 8;
  localparam int DATA_W      = 32;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int FRAC_W      = 16;
  localparam int DIVC_W      = $clog2(FRAC_W);
  localparam int PROD_W      = FRAC_W + 1 + DIFF_W;
  localparam int REGION_W    = 3;
  localparam int IN_W        = INDEX_W + 3 * DATA_W;
  localparam int OUT_W       = 8 * ((DATA_W + REGION_W + 7) / 8);
  localparam int KNOT_W      = 2 * DATA_W;

  localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(FRAC_W - 1);

  // Item kinds carried in s_tuser.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [REGION_W-1:0] {
    REG_EMPTY    = 3'd0,
    REG_LOW      = 3'd1,
    REG_HIGH     = 3'd2,
    REG_INTERIOR = 3'd3,
    REG_ZERO_W   = 3'd4
  } region_t;

  // Datapath operation selected by a control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_EMPTY,
    OP_LOW,
    OP_HIGH,
    OP_SCAN,
    OP_DIFF,
    OP_GUARD,
    OP_DIV,
    OP_MUL,
    OP_SUM,
    OP_EMIT
  } op_t;

  // Source of the table read address.
  typedef enum logic [1:0] {
    A_ZERO,
    A_LAST,
    A_ONE,
    A_PTR_INC
  } asel_t;

  // Jump condition; when it holds the step counter loads the target.
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_QUERY,
    COND_N_ZERO,
    COND_Q_LE_X,
    COND_Q_GE_X,
    COND_X_LT_Q,
    COND_DX_NONPOS,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [3:0] pc_t;

  localparam pc_t P_IDLE  = 4'd0;
  localparam pc_t P_START = 4'd1;
  localparam pc_t P_LOW   = 4'd2;
  localparam pc_t P_HIGH  = 4'd3;
  localparam pc_t P_SCAN  = 4'd4;
  localparam pc_t P_DIFF  = 4'd5;
  localparam pc_t P_GUARD = 4'd6;
  localparam pc_t P_DIV   = 4'd7;
  localparam pc_t P_MUL   = 4'd8;
  localparam pc_t P_SUM   = 4'd9;
  localparam pc_t P_EMIT  = 4'd10;
  localparam pc_t P_DONE  = 4'd11;

  typedef struct packed {
    op_t   op;
    asel_t asel;
    cond_t cond;
    pc_t   target;
  } ctl_t;

  // The program: one control word per step.
  function automatic ctl_t prog_rom(input pc_t step);
    ctl_t w;
    unique case (step)
      P_IDLE:  w = '{OP_ACCEPT, A_ZERO,    COND_NO_QUERY,  P_IDLE};
      P_START: w = '{OP_EMPTY,  A_ZERO,    COND_N_ZERO,    P_EMIT};
      P_LOW:   w = '{OP_LOW,    A_LAST,    COND_Q_LE_X,    P_EMIT};
      P_HIGH:  w = '{OP_HIGH,   A_ONE,     COND_Q_GE_X,    P_EMIT};
      P_SCAN:  w = '{OP_SCAN,   A_PTR_INC, COND_X_LT_Q,    P_SCAN};
      P_DIFF:  w = '{OP_DIFF,   A_ZERO,    COND_NEVER,     P_IDLE};
      P_GUARD: w = '{OP_GUARD,  A_ZERO,    COND_DX_NONPOS, P_EMIT};
      P_DIV:   w = '{OP_DIV,    A_ZERO,    COND_DIV_MORE,  P_DIV};
      P_MUL:   w = '{OP_MUL,    A_ZERO,    COND_NEVER,     P_IDLE};
      P_SUM:   w = '{OP_SUM,    A_ZERO,    COND_NEVER,     P_IDLE};
      P_EMIT:  w = '{OP_EMIT,   A_ZERO,    COND_OUT_BUSY,  P_EMIT};
      P_DONE:  w = '{OP_NONE,   A_ZERO,    COND_ALWAYS,    P_IDLE};
      default: w = '{OP_NONE,   A_ZERO,    COND_ALWAYS,    P_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/clin_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module clin_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/clamped_linear_interpolator.sv
// Top level of the clamped piecewise-linear table interpolator.
`timescale 1ns / 1ps

// Channel   Direction  Signals                        Contents
// s_        in         s_tvalid s_tready s_tdata      load knot or query
//                      s_tuser                        (s_tuser: 0 load, 1 query)
// m_        out        m_tvalid m_tready m_tdata      interpolated value, region
// cfg_      in         cfg_we cfg_wdata               point_count register
//
// A load writes the knot to the table on acceptance.
// A query ends early on an empty table or when clamped low or high; for an
// interval its duration is set by the linear interval search (one table read
// per cycle) and the 16-step restoring divider.
// Reset clears the step counter, the output valid and point_count; the table
// itself holds whatever was last written and needs no clearing.
// A stalled output only holds the sequencer at its emit step; the result sits
// in the output register so the next item can be accepted meanwhile.
module clamped_linear_interpolator (
  input  logic                          clk,
  input  logic                          rst,
  // Slave stream. tdata, low bit up: entry_index[7:0], knot_x[31:0],
  // knot_y[31:0], query_x[31:0].
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [clin_pkg::IN_W-1:0]     s_tdata,
  // tuser: action (0 load, 1 query).
  input  logic                          s_tuser,
  // Master stream. tdata, low bit up: value[31:0], region[2:0], zero pad.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [clin_pkg::OUT_W-1:0]    m_tdata,
  // Configuration write of point_count.
  input  logic                          cfg_we,
  input  logic [clin_pkg::COUNT_W-1:0]  cfg_wdata
);

  // Unpacked input fields.
  logic        [clin_pkg::INDEX_W-1:0] entry_index;
  logic signed [clin_pkg::DATA_W-1:0]  knot_x;
  logic signed [clin_pkg::DATA_W-1:0]  knot_y;
  logic signed [clin_pkg::DATA_W-1:0]  query_x;

  assign entry_index = s_tdata[clin_pkg::INDEX_W-1:0];
  assign knot_x      = s_tdata[clin_pkg::INDEX_W +: clin_pkg::DATA_W];
  assign knot_y      = s_tdata[clin_pkg::INDEX_W + clin_pkg::DATA_W +: clin_pkg::DATA_W];
  assign query_x     = s_tdata[clin_pkg::INDEX_W + 2 * clin_pkg::DATA_W +: clin_pkg::DATA_W];

  // Configuration register and the knot count actually in use.
  logic [clin_pkg::COUNT_W-1:0] point_count;
  logic [clin_pkg::CNT_W-1:0]   n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  assign n_eff = (32'(point_count) > clin_pkg::TABLE_DEPTH)
               ? clin_pkg::CNT_W'(clin_pkg::TABLE_DEPTH)
               : clin_pkg::CNT_W'(point_count);

  // Sequencer: step counter and the control word it selects.
  clin_pkg::pc_t  pc;
  clin_pkg::pc_t  pc_next;
  clin_pkg::ctl_t ctl;
  logic           jump;

  assign ctl = clin_pkg::prog_rom(pc);

  // Handshake qualifiers.
  logic in_acc;
  logic query_acc;
  logic load_acc;
  logic out_busy;

  assign s_tready  = (pc == clin_pkg::P_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign query_acc = in_acc && (s_tuser == clin_pkg::ACT_QUERY);
  assign load_acc  = in_acc && (s_tuser == clin_pkg::ACT_LOAD);
  assign out_busy  = m_tvalid && !m_tready;

  // Knot table: {ordinate, abscissa} per entry.
  logic                              ram_we;
  logic [clin_pkg::ADDR_W-1:0]       raddr;
  logic [clin_pkg::KNOT_W-1:0]       rdata;
  logic signed [clin_pkg::DATA_W-1:0] rd_x;
  logic signed [clin_pkg::DATA_W-1:0] rd_y;

  assign ram_we = load_acc && (32'(entry_index) < clin_pkg::TABLE_DEPTH);
  assign rd_x   = rdata[clin_pkg::DATA_W-1:0];
  assign rd_y   = rdata[clin_pkg::KNOT_W-1:clin_pkg::DATA_W];

  clin_ram #(
    .WIDTH (clin_pkg::KNOT_W),
    .DEPTH (clin_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (clin_pkg::ADDR_W'(entry_index)),
    .wdata ({knot_y, knot_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Datapath registers.
  logic signed [clin_pkg::DATA_W-1:0] q;
  logic signed [clin_pkg::DATA_W-1:0] xl;
  logic signed [clin_pkg::DATA_W-1:0] yl;
  logic signed [clin_pkg::DATA_W-1:0] xh;
  logic signed [clin_pkg::DATA_W-1:0] yh;
  logic signed [clin_pkg::DIFF_W-1:0] dx;
  logic signed [clin_pkg::DIFF_W-1:0] num;
  logic signed [clin_pkg::DIFF_W-1:0] dy;
  logic        [clin_pkg::DIFF_W-1:0] rem;
  logic        [clin_pkg::FRAC_W-1:0] quo;
  logic        [clin_pkg::DIVC_W-1:0] div_cnt;
  logic        [clin_pkg::ADDR_W-1:0] ptr;
  logic signed [clin_pkg::PROD_W-1:0] prod;
  logic signed [clin_pkg::DATA_W-1:0] res_value;
  clin_pkg::region_t                  res_region;

  // One restoring divide step: shift the remainder and try to subtract dx.
  logic [clin_pkg::DIFF_W:0] rem_shift;
  logic [clin_pkg::DIFF_W:0] rem_diff;
  logic                      div_ge;

  assign rem_shift = {rem, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, dx};
  assign div_ge    = rem_shift >= {1'b0, dx};

  // Read address and jump condition decode.
  always_comb begin
    unique case (ctl.asel)
      clin_pkg::A_ZERO:    raddr = '0;
      clin_pkg::A_LAST:    raddr = clin_pkg::ADDR_W'(n_eff - 1'b1);
      clin_pkg::A_ONE:     raddr = clin_pkg::ADDR_W'(1);
      clin_pkg::A_PTR_INC: raddr = clin_pkg::ADDR_W'(ptr + 1'b1);
      default:             raddr = '0;
    endcase

    unique case (ctl.cond)
      clin_pkg::COND_NEVER:     jump = 1'b0;
      clin_pkg::COND_ALWAYS:    jump = 1'b1;
      clin_pkg::COND_NO_QUERY:  jump = !query_acc;
      clin_pkg::COND_N_ZERO:    jump = (n_eff == '0);
      clin_pkg::COND_Q_LE_X:    jump = (q <= rd_x);
      clin_pkg::COND_Q_GE_X:    jump = (q >= rd_x);
      clin_pkg::COND_X_LT_Q:    jump = (rd_x < q);
      clin_pkg::COND_DX_NONPOS: jump = dx[clin_pkg::DIFF_W-1] || (dx == '0);
      clin_pkg::COND_DIV_MORE:  jump = (div_cnt != clin_pkg::DIV_LAST);
      clin_pkg::COND_OUT_BUSY:  jump = out_busy;
      default:                  jump = 1'b0;
    endcase

    pc_next = jump ? ctl.target : clin_pkg::pc_t'(pc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= clin_pkg::P_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Datapath: each control word performs one operation.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      clin_pkg::OP_NONE: begin
      end
      clin_pkg::OP_ACCEPT: begin
        if (in_acc) begin
          q <= query_x;
        end
      end
      clin_pkg::OP_EMPTY: begin
        res_value  <= '0;
        res_region <= clin_pkg::REG_EMPTY;
      end
      clin_pkg::OP_LOW: begin
        // The first knot is both the low clamp and the first lower bound.
        xl         <= rd_x;
        yl         <= rd_y;
        res_value  <= rd_y;
        res_region <= clin_pkg::REG_LOW;
      end
      clin_pkg::OP_HIGH: begin
        res_value  <= rd_y;
        res_region <= clin_pkg::REG_HIGH;
        ptr        <= clin_pkg::ADDR_W'(1);
      end
      clin_pkg::OP_SCAN: begin
        // Knots below the query move the lower bound up; the first one that
        // is not below it closes the interval.
        if (rd_x < q) begin
          xl  <= rd_x;
          yl  <= rd_y;
          ptr <= clin_pkg::ADDR_W'(ptr + 1'b1);
        end else begin
          xh <= rd_x;
          yh <= rd_y;
        end
      end
      clin_pkg::OP_DIFF: begin
        dx  <= {xh[clin_pkg::DATA_W-1], xh} - {xl[clin_pkg::DATA_W-1], xl};
        num <= {q[clin_pkg::DATA_W-1], q} - {xl[clin_pkg::DATA_W-1], xl};
        dy  <= {yh[clin_pkg::DATA_W-1], yh} - {yl[clin_pkg::DATA_W-1], yl};
      end
      clin_pkg::OP_GUARD: begin
        res_value  <= yl;
        res_region <= clin_pkg::REG_ZERO_W;
        rem        <= num[clin_pkg::DIFF_W-1] ? '0 : num;
        quo        <= '0;
        div_cnt    <= '0;
      end
      clin_pkg::OP_DIV: begin
        // A query on the upper knot keeps rem equal to dx, so every bit is
        // one and the fraction lands on its all-ones maximum.
        rem     <= div_ge ? clin_pkg::DIFF_W'(rem_diff) : clin_pkg::DIFF_W'(rem_shift);
        quo     <= {quo[clin_pkg::FRAC_W-2:0], div_ge};
        div_cnt <= clin_pkg::DIVC_W'(div_cnt + 1'b1);
      end
      clin_pkg::OP_MUL: begin
        prod <= $signed({1'b0, quo}) * dy;
      end
      clin_pkg::OP_SUM: begin
        // Dropping the low fraction bits of a signed product floors it.
        res_value  <= yl + prod[clin_pkg::FRAC_W + clin_pkg::DATA_W - 1:clin_pkg::FRAC_W];
        res_region <= clin_pkg::REG_INTERIOR;
      end
      clin_pkg::OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded at the emit step once the previous result left.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((ctl.op == clin_pkg::OP_EMIT) && !out_busy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.op == clin_pkg::OP_EMIT) && !out_busy) begin
      m_tdata <= clin_pkg::OUT_W'({res_region, res_value});
    end
  end

  // A query always starts the program at its first step.
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> (pc == clin_pkg::P_START))
    else $error("query transaction did not start the program");

  // A load produces no result and leaves the sequencer ready.
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> (pc == clin_pkg::P_IDLE))
    else $error("load transaction left the idle step");

  // A result appears only from the emit step.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(pc) == clin_pkg::P_EMIT))
    else $error("output became valid outside the emit step");

  // The multiply follows a complete division.
  a_div_complete: assert property (@(posedge clk) disable iff (rst)
    (pc == clin_pkg::P_MUL) |->
      ($past(pc) == clin_pkg::P_DIV) && ($past(div_cnt) == clin_pkg::DIV_LAST))
    else $error("multiply started before the division finished");

endmodule

### dv/clamped_linear_interpolator_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the clamped linear interpolator.
module clamped_linear_interpolator_test;
  import clin_pkg::*;

  // After the last answer arrives, only a knot load can still be in flight,
  // and the pause before a register write or the final verdict is longer than
  // the longest query.
  localparam int SETTLE_CYCLES = 300;
  // Directed transactions plus the random part.
  localparam int ITEM_TARGET   = 1370;
  localparam int DIRECTED_LEN  = 21;

  // One interpolation answer as the block reports it.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    region_t           region;
  } interp_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_QUERY
  } row_kind_t;

  // A directed stimulus row. Only rows with typed set carry their answer;
  // the others are checked against the predictor.
  typedef struct packed {
    row_kind_t          kind;
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  kx;
    logic [DATA_W-1:0]  ky;
    logic [DATA_W-1:0]  qx;
    logic               typed;
    logic [DATA_W-1:0]  exp_value;
    region_t            exp_region;
  } stim_row_t;

  // The knots below give three intervals: a very wide falling one from the
  // most negative abscissa to zero, a narrow one up to 1.0, and a long one to
  // the most positive abscissa. Entry 255 is written only to touch the top
  // index.
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0000_0000, 32'h0, 32'h0000_0000, 1'b1, 32'h0, REG_EMPTY},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1, 32'h0, REG_EMPTY},
    '{ROW_LOAD,  9'd0, 8'd0,   32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_LOAD,  9'd0, 8'd1,   32'h0000_0000, 32'h8000_0000, 32'h0, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_LOAD,  9'd0, 8'd2,   32'h0001_0000, 32'h0003_0000, 32'h0, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_LOAD,  9'd0, 8'd3,   32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_LOAD,  9'd0, 8'd255, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_CFG,   9'd1, 8'd0,   32'h0, 32'h0, 32'h0, 1'b0, 32'h0, REG_EMPTY},
    // A single knot: at or below it clamps low, above it clamps high.
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, REG_LOW},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h0000_0005, 1'b1, 32'h7FFF_FFFF, REG_HIGH},
    '{ROW_CFG,   9'd4, 8'd0,   32'h0, 32'h0, 32'h0, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, REG_LOW},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_0000, REG_HIGH},
    // Query on an upper knot: the fraction saturates just below one.
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h0000_0000, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'hC000_0000, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h0000_8000, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h0001_0000, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h4000_0000, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h8000_0001, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_CFG,   9'd0, 8'd0,   32'h0, 32'h0, 32'h0, 1'b0, 32'h0, REG_EMPTY},
    '{ROW_QUERY, 9'd0, 8'd0,   32'h0, 32'h0, 32'h1234_5678, 1'b1, 32'h0, REG_EMPTY}
  };

  logic                clk;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata   = '0;
  logic                s_tuser   = ACT_LOAD;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                cfg_we    = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;

  // Our own copy of the knot table and of point_count, updated as the block
  // accepts loads and register writes.
  logic signed [DATA_W-1:0] knot_x_shadow [TABLE_DEPTH];
  logic signed [DATA_W-1:0] knot_y_shadow [TABLE_DEPTH];
  logic [COUNT_W-1:0]       count_shadow = '0;

  // Answers owed by the block, oldest first.
  interp_result_t answers_due [$];

  int unsigned mismatches     = 0;
  int unsigned items_sent     = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  clamped_linear_interpolator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Piecewise-linear value of the shadow table at abscissa q. The clamps are
  // tested low end first; the interval search stops at the first upper knot
  // that is not below q, which also guarantees a positive interval width.
  function automatic interp_result_t interpolate_at(input logic signed [DATA_W-1:0] q);
    interp_result_t r;
    int unsigned    n;
    int unsigned    i;
    longint         lo_x, hi_x, lo_y, hi_y, span, offset, frac;
    n = (32'(count_shadow) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(count_shadow);
    r.value  = '0;
    r.region = REG_EMPTY;
    if (n == 0) return r;
    if (q <= knot_x_shadow[0]) begin
      r.value  = knot_y_shadow[0];
      r.region = REG_LOW;
      return r;
    end
    if (q >= knot_x_shadow[ADDR_W'(n-1)]) begin
      r.value  = knot_y_shadow[ADDR_W'(n-1)];
      r.region = REG_HIGH;
      return r;
    end
    i = 0;
    while (i + 1 < n && knot_x_shadow[ADDR_W'(i+1)] < q) i++;
    lo_x = longint'(knot_x_shadow[ADDR_W'(i)]);
    hi_x = longint'(knot_x_shadow[ADDR_W'(i+1)]);
    lo_y = longint'(knot_y_shadow[ADDR_W'(i)]);
    hi_y = longint'(knot_y_shadow[ADDR_W'(i+1)]);
    span = hi_x - lo_x;
    if (span <= 0) begin
      r.value  = knot_y_shadow[ADDR_W'(i)];
      r.region = REG_ZERO_W;
      return r;
    end
    offset = longint'(q) - lo_x;
    if (offset < 0) offset = 0;
    // Unsigned Q0.16 fraction, truncated and saturated below one.
    frac = (offset <<< FRAC_W) / span;
    if (frac > 65535) frac = 65535;
    // The product keeps its sign; the arithmetic shift floors it.
    r.value  = DATA_W'(lo_y + ((frac * (hi_y - lo_y)) >>> FRAC_W));
    r.region = REG_INTERIOR;
    return r;
  endfunction

  // Present one transaction at a falling edge, with random idle cycles in
  // front of it, and hold it until the block takes it at a rising edge.
  task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] kx, input logic [DATA_W-1:0] ky,
                           input logic [DATA_W-1:0] qx, input bit typed,
                           input interp_result_t typed_answer);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {qx, ky, kx, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (act == ACT_LOAD) begin
      knot_x_shadow[idx] = kx;
      knot_y_shadow[idx] = ky;
    end else if (typed) begin
      answers_due.push_back(typed_answer);
    end else begin
      answers_due.push_back(interpolate_at(qx));
    end
  endtask

  // Loads and queries fill the fields they do not use with random bits.
  task automatic load_knot(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] kx,
                           input logic [DATA_W-1:0] ky);
    send_item(ACT_LOAD, idx, kx, ky, $urandom, 1'b0, '0);
  endtask

  task automatic ask_at(input logic [DATA_W-1:0] qx);
    send_item(ACT_QUERY, INDEX_W'($urandom), $urandom, $urandom, qx, 1'b0, '0);
  endtask

  // Drop valid, wait until every answer is in, then let the block go idle.
  task automatic settle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_point_count(input logic [COUNT_W-1:0] setting);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= setting;
    @(negedge clk);
    cfg_we    <= 1'b0;
    count_shadow = setting;
  endtask

  // Write knots 0..n-1. Most shapes are sorted: spread over the whole range,
  // packed into a narrow window, or with repeated abscissas. The last shape
  // is unsorted noise.
  task automatic fill_table(input int unsigned n);
    int unsigned shape;
    int unsigned lo_step;
    longint      step_cap;
    longint      x_pos;
    logic [DATA_W-1:0] kx;
    logic [DATA_W-1:0] ky;
    shape   = $urandom_range(3);
    lo_step = 1;
    case (shape)
      0: step_cap = 64'hFFFF_FFFF / n;
      1: step_cap = longint'($urandom_range(1 << 16, 1));
      2: begin
        step_cap = 3;
        lo_step  = 0;
      end
      default: step_cap = 1;
    endcase
    // Start low enough that n steps of at most step_cap cannot overflow.
    x_pos = -64'sd2147483648 + longint'($urandom_range(32'(64'hFFFF_FFFF - n * step_cap), 0));
    for (int unsigned k = 0; k < n; k++) begin
      kx = (shape == 3) ? $urandom : DATA_W'(x_pos);
      x_pos += longint'($urandom_range(32'(step_cap), lo_step));
      if ($urandom_range(7) == 0) begin
        ky = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
        ky = $urandom;
      end
      load_knot(INDEX_W'(k), kx, ky);
    end
  endtask

  // Mostly queries inside a chosen interval, with exact knot hits, fully
  // random abscissas and stray knot rewrites mixed in.
  task automatic query_mix(input int unsigned n, input int unsigned rounds);
    int unsigned pick;
    int unsigned i;
    longint      span;
    for (int unsigned j = 0; j < rounds; j++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        load_knot(INDEX_W'($urandom), $urandom, $urandom);
      end else if (pick < 25 || n < 2) begin
        ask_at($urandom);
      end else if (pick < 35) begin
        ask_at(knot_x_shadow[ADDR_W'($urandom_range(n - 1))]);
      end else begin
        i    = $urandom_range(n - 2);
        span = longint'(knot_x_shadow[ADDR_W'(i+1)]) - longint'(knot_x_shadow[ADDR_W'(i)]);
        if (span <= 0) begin
          ask_at(knot_x_shadow[ADDR_W'(i)]);
        end else begin
          ask_at(DATA_W'(longint'(knot_x_shadow[ADDR_W'(i)])
                         + longint'($urandom_range(32'(span), 1))));
        end
      end
    end
  endtask

  // Answers are checked as they are taken at the rising edge.
  task automatic check_answer(input logic [OUT_W-1:0] data);
    interp_result_t      want;
    logic [DATA_W-1:0]   got_value;
    logic [REGION_W-1:0] got_region;
    got_value  = data[DATA_W-1:0];
    got_region = data[DATA_W +: REGION_W];
    if (answers_due.size() == 0) begin
      $display("%0t ns: answer with none outstanding: value %h region %0d",
               $time, got_value, got_region);
      mismatches++;
    end else begin
      want = answers_due.pop_front();
      if (got_value !== want.value) begin
        $display("%0t ns: value mismatch: expected %h, actual %h",
                 $time, want.value, got_value);
        mismatches++;
      end
      if (got_region !== want.region) begin
        $display("%0t ns: region mismatch: expected %0d, actual %0d",
                 $time, want.region, got_region);
        mismatches++;
      end
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_answer(m_tdata);
  end

  initial begin : stimulus
    stim_row_t          row;
    interp_result_t     typed_answer;
    int unsigned        phase;
    logic [COUNT_W-1:0] setting;
    int unsigned        n;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part, no idling.
    for (int r = 0; r < DIRECTED_LEN; r++) begin
      row = DIRECTED_ROWS[r];
      typed_answer.value  = row.exp_value;
      typed_answer.region = row.exp_region;
      case (row.kind)
        ROW_CFG: begin
          set_point_count(row.count);
        end
        ROW_LOAD: begin
          send_item(ACT_LOAD, row.index, row.kx, row.ky, row.qx, 1'b0, '0);
        end
        default: begin
          send_item(ACT_QUERY, row.index, row.kx, row.ky, row.qx, row.typed, typed_answer);
        end
      endcase
    end

    // Random phases. Each one writes point_count while the block is idle,
    // reloads every knot in use, then queries. The full table, exactly 256
    // and oversized counts come up in a few phases only, since long interval
    // searches are slow.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 79;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 79;
        end
        default: begin
          src_idle_pct   = 26;
          sink_stall_pct = 26;
        end
      endcase
      if (phase == 1) begin
        setting = COUNT_W'(TABLE_DEPTH);
      end else if (phase == 4) begin
        setting = '1;
      end else if (phase == 8) begin
        setting = COUNT_W'($urandom_range(510, TABLE_DEPTH + 1));
      end else begin
        case ($urandom_range(9))
          0:       setting = '0;
          1:       setting = COUNT_W'(1);
          default: setting = COUNT_W'($urandom_range(16, 2));
        endcase
      end
      set_point_count(setting);
      n = (32'(setting) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(setting);
      if (n > 0) fill_table(n);
      query_mix(n, (n == TABLE_DEPTH) ? 30 : $urandom_range(50, 30));
      phase++;
    end

    settle();
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Several times the slowest correct run.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
